@@ rtl/u8cp_pkg.sv @@
// shared types and constants for the utf-8 to code page 437 converter
package u8cp_pkg;

  // lookup table size and derived widths
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // op queue between decoder and lookup engine
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 1'd1;
  localparam logic [7:0]           FALLBACK_RESET = 8'd168;

  // utf-8 byte classes
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_MATCH  = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_MATCH = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_MATCH = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_MATCH = 8'hF0;
  localparam logic [7:0] PAY2_MASK   = 8'h1F;
  localparam logic [7:0] PAY3_MASK   = 8'h0F;
  localparam logic [7:0] PAY4_MASK   = 8'h07;
  localparam logic [7:0] PAYC_MASK   = 8'h3F;

  // codepoint thresholds
  localparam logic [15:0] CP_PRINTABLE = 16'h0020;
  localparam logic [15:0] CP_ASCII_END = 16'h0080;
  localparam logic [15:0] CP_MIN_THREE = 16'h0800;

  // open sequence kind
  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } u8cp_seq_t;

  // queued operation
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } u8cp_kind_t;

  typedef struct packed {
    u8cp_kind_t        kind;
    logic [15:0]       key;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        code;
  } u8cp_op_t;

  typedef struct packed {
    logic     valid;
    u8cp_op_t op;
  } u8cp_push_t;

  typedef struct packed {
    logic     avail;
    u8cp_op_t op;
  } u8cp_head_t;

  // lookup engine states
  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_SEARCH = 2'd1,
    B_EMIT   = 2'd2
  } u8cp_bstate_t;

endpackage

@@ rtl/u8cp_if.sv @@
// channel interfaces for the input beats and the result beats
interface u8cp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  byte_in;
  logic [7:0]  entry_index;
  logic [15:0] entry_codepoint;
  logic [7:0]  entry_code;

  modport source (output valid, mode, byte_in, entry_index, entry_codepoint, entry_code,
                  input ready);
  modport sink (input valid, mode, byte_in, entry_index, entry_codepoint, entry_code,
                output ready);
endinterface

interface u8cp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, char_code, input ready);
  modport sink (input valid, char_code, output ready);
endinterface

@@ rtl/u8cp_front.sv @@
// utf-8 decoder front end: accepts beats, builds codepoints, queues loads and lookups
module u8cp_front import u8cp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  u8cp_in_if.sink    in_ch,
  input  logic       q_full,
  output u8cp_push_t push
);

  logic [1:0]  pend, pend_next;
  u8cp_seq_t   kind, kind_next;
  logic [15:0] part, part_next;
  logic [15:0] cp;
  logic [15:0] shifted;
  logic [7:0]  b;
  logic        accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_in;
  assign shifted     = {part[9:0], b[5:0]};

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
      kind <= SEQ_NONE;
      part <= 16'h0;
    end else begin
      pend <= pend_next;
      kind <= kind_next;
      part <= part_next;
    end
  end

  // byte classification and op build
  always_comb begin
    pend_next     = pend;
    kind_next     = kind;
    part_next     = part;
    cp            = 16'h0;
    push.valid    = 1'b0;
    push.op.kind  = OP_LOOKUP;
    push.op.key   = in_ch.entry_codepoint;
    push.op.idx   = IDX_W'(in_ch.entry_index);
    push.op.code  = in_ch.entry_code;
    if (accept) begin
      if (!in_ch.mode) begin
        // table load, dropped when the slot is beyond the table
        push.op.kind = OP_LOAD;
        push.valid   = 32'(in_ch.entry_index) < TABLE_DEPTH;
      end else begin
        if (pend != 2'd0 && (b & CONT_MASK) == CONT_MATCH) begin
          // continuation of an open sequence
          pend_next = pend - 2'd1;
          part_next = shifted;
          if (pend == 2'd1) begin
            part_next = 16'h0;
            kind_next = SEQ_NONE;
            if (kind == SEQ_TWO && shifted >= CP_ASCII_END) begin
              cp = shifted;
            end else if (kind == SEQ_THREE && shifted >= CP_MIN_THREE) begin
              cp = shifted;
            end
          end
        end else begin
          // fresh byte, any open sequence is dropped
          pend_next = 2'd0;
          kind_next = SEQ_NONE;
          part_next = 16'h0;
          if (!b[7]) begin
            cp = {8'h0, b};
          end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
            part_next = {8'h0, b & PAY2_MASK};
            pend_next = 2'd1;
            kind_next = SEQ_TWO;
          end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
            part_next = {8'h0, b & PAY3_MASK};
            pend_next = 2'd2;
            kind_next = SEQ_THREE;
          end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
            part_next = {8'h0, b & PAY4_MASK};
            pend_next = 2'd3;
            kind_next = SEQ_FOUR;
          end
        end
        // control codes give nothing
        push.op.key = cp;
        push.valid  = cp >= CP_PRINTABLE;
      end
    end
  end

endmodule

@@ rtl/u8cp_queue.sv @@
// short op queue between the decoder and the lookup engine
module u8cp_queue import u8cp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  u8cp_push_t push,
  output logic       full,
  input  logic       pop,
  output u8cp_head_t head
);

  u8cp_op_t        slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full      = count == (Q_AW+1)'(Q_DEPTH);
  assign head.avail = count != '0;
  assign head.op    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/u8cp_back.sv @@
// lookup engine: table memory, binary search and the result register
module u8cp_back import u8cp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  u8cp_head_t            head,
  output logic                  pop,
  input  logic [CFG_DATA_W-1:0] entries_in_use,
  input  logic [7:0]            fallback_code,
  u8cp_out_if.source            out_ch
);

  logic [15:0]      key_mem  [TABLE_DEPTH];
  logic [7:0]       code_mem [TABLE_DEPTH];
  logic [15:0]      key_rd;
  logic [7:0]       code_rd;

  u8cp_bstate_t     state, state_next;
  logic [CNT_W-1:0] lo, lo_next, hi, hi_next;
  logic [IDX_W-1:0] mid, mid_next;
  logic [15:0]      cp_key, cp_key_next;
  logic [7:0]       result, result_next;

  logic             wr_en;
  logic             rd_en;
  logic             load_out;
  logic             out_valid;
  logic [7:0]       out_code;
  logic             out_free;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] lo_n, hi_n;
  logic [CNT_W:0]   probe;

  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = out_code;
  assign out_free         = !out_valid || out_ch.ready;

  // search bound saturated at the table size
  always_comb begin
    if (32'(entries_in_use) > TABLE_DEPTH) begin
      n = CNT_W'(TABLE_DEPTH);
    end else begin
      n = CNT_W'(entries_in_use);
    end
  end

  // table memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[head.op.idx]  <= head.op.key;
      code_mem[head.op.idx] <= head.op.code;
    end
    if (rd_en) begin
      key_rd  <= key_mem[mid_next];
      code_rd <= code_mem[mid_next];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search registers and result beat
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    cp_key <= cp_key_next;
    result <= result_next;
    if (load_out) begin
      out_code <= result;
    end
  end

  // sequencer
  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    cp_key_next = cp_key;
    result_next = result;
    pop         = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    lo_n        = lo;
    hi_n        = hi;
    probe       = '0;
    unique case (state)
      B_IDLE: begin
        if (head.avail) begin
          pop = 1'b1;
          unique case (head.op.kind)
            OP_LOAD: begin
              wr_en = 1'b1;
            end
            OP_LOOKUP: begin
              cp_key_next = head.op.key;
              if (head.op.key < CP_ASCII_END) begin
                // printable ascii passes straight through
                result_next = head.op.key[7:0];
                state_next  = B_EMIT;
              end else if (n == '0) begin
                result_next = fallback_code;
                state_next  = B_EMIT;
              end else begin
                lo_next    = '0;
                hi_next    = n;
                probe      = (CNT_W+1)'(n) - (CNT_W+1)'(1);
                mid_next   = probe[IDX_W:1];
                rd_en      = 1'b1;
                state_next = B_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      B_SEARCH: begin
        if (key_rd == cp_key) begin
          result_next = code_rd;
          state_next  = B_EMIT;
        end else begin
          // halve the open range [lo, hi)
          if (key_rd < cp_key) begin
            lo_n = CNT_W'(mid) + CNT_W'(1);
          end else begin
            hi_n = CNT_W'(mid);
          end
          lo_next = lo_n;
          hi_next = hi_n;
          if (lo_n < hi_n) begin
            probe    = (CNT_W+1)'(lo_n) + (CNT_W+1)'(hi_n) - (CNT_W+1)'(1);
            mid_next = probe[IDX_W:1];
            rd_en    = 1'b1;
          end else begin
            result_next = fallback_code;
            state_next  = B_EMIT;
          end
        end
      end
      B_EMIT: begin
        // a zero code means suppress
        if (result == 8'h0) begin
          state_next = B_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/utf8_to_cp437_converter.sv @@
// top level of the utf-8 to code page 437 converter
//
// in_ch takes one beat per item: mode 0 loads a table slot (entry_index,
// entry_codepoint, entry_code), mode 1 feeds one utf-8 byte. out_ch gives one
// beat per code page 437 character. the user must load the table in ascending
// codepoint order; the block does not enforce it. entries_in_use and
// fallback_code are set through the write port. the front decoder takes a beat
// every cycle while its four-entry op queue has room; the lookup engine pops
// a queued op only from idle and finishes it before it takes the next: a table
// load is written to the table memory, printable ascii goes to the emit state,
// and other codepoints run a binary search, one probe per read of the single
// read port of the table memory. dropped bytes cost no engine time. reset
// clears the decoder, the queue and the result valid flag, sets entries_in_use
// to 0 and fallback_code to 168; table slots are undefined until loaded. when
// out_ch stalls the result is held, the engine waits, the queue fills and
// in_ch.ready drops.
module utf8_to_cp437_converter import u8cp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  u8cp_in_if.sink               in_ch,
  u8cp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_DATA_W-1:0] entries_in_use;
  logic [7:0]            fallback_code;
  u8cp_push_t            push;
  u8cp_head_t            head;
  logic                  q_full;
  logic                  pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      fallback_code  <= FALLBACK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTRIES:  entries_in_use <= cfg_wdata;
        REG_FALLBACK: fallback_code  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  u8cp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  u8cp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  u8cp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .entries_in_use (entries_in_use),
    .fallback_code  (fallback_code),
    .out_ch         (out_ch)
  );

endmodule
